/* src/cdfe_pkg.sv */
// Shared types, constants and the CRC-8 byte update for the debug frame encoder.
package cdfe_pkg;

  // Field widths
  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 7;
  localparam int CFG_IDX_W = 2;

  // Payload length limits and the offset carried in the length byte
  localparam int MAX_PAYLOAD = 127;
  localparam int LEN_EXTRA   = 3;

  // Fixed frame bytes
  localparam logic [BYTE_W-1:0] HDR_BYTE0 = 8'h23;
  localparam logic [BYTE_W-1:0] HDR_BYTE1 = 8'h25;
  localparam logic [BYTE_W-1:0] TAIL_CR   = 8'h0D;
  localparam logic [BYTE_W-1:0] TAIL_LF   = 8'h0A;

  // Register reset values
  localparam logic [BYTE_W-1:0] CRC_POLY_RST = 8'hD5;
  localparam logic [BYTE_W-1:0] CMD_CODE_RST = 8'hC1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CRC_POLY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CMD_CODE = 2'd1;

  // Position of the outgoing byte within the frame
  typedef enum logic [3:0] {
    PH_HDR0,
    PH_HDR1,
    PH_CMD,
    PH_LEN,
    PH_LVL,
    PH_DATA,
    PH_CRC,
    PH_CR,
    PH_LF
  } phase_t;

  // One accepted item as held for the serializer
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic [BYTE_W-1:0] level;
    logic [BYTE_W-1:0] len_byte;
    logic              first;
    logic              last;
  } job_t;

  // MSB-first, non-reflected CRC-8 over one byte
  function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] data,
                                                    input logic [BYTE_W-1:0] poly);
    logic [BYTE_W-1:0] v;
    v = crc ^ data;
    for (int b = 0; b < BYTE_W; b++) begin
      if (v[BYTE_W-1]) begin
        v = (v << 1) ^ poly;
      end else begin
        v = v << 1;
      end
    end
    return v;
  endfunction

endpackage

/* src/cdfe_in_if.sv */
// Input item channel: one payload byte with its frame flags.
interface cdfe_in_if
  import cdfe_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic [BYTE_W-1:0] message_level;
  logic [LEN_W-1:0]  payload_length;
  logic              first_byte;
  logic              last_byte;

  modport source (output valid, data_byte, message_level, payload_length,
                  first_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, message_level, payload_length,
                  first_byte, last_byte, output ready);
endinterface

/* src/cdfe_out_if.sv */
// Result item channel: one framed byte with its end markers.
interface cdfe_out_if
  import cdfe_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              run_last;
  logic              frame_end;

  modport source (output valid, out_byte, run_last, frame_end, input ready);
  modport sink   (input valid, out_byte, run_last, frame_end, output ready);
endinterface

/* src/crc8_debug_frame_encoder.sv */
// Top level of the CRC-8 debug frame encoder: configuration registers and the two stages.
//
// Frames debug message bytes for a serial link. An input item marked first makes the
// header 0x23 0x25 <command> <length+3> <level>, every item in a frame yields its payload
// byte, and an item marked last adds the CRC-8 (MSB-first, init 0, over command, length,
// level and payload), CR and LF. Items with first clear outside a frame are dropped.
// An item is held in one job register and a sequencer moves one byte per cycle into the
// output register while the output is not stalled. A plain payload byte yields 1 byte, a last
// byte 4, a first byte 6, first and last together 9; a dropped item yields none and is not held.
// Plain payload items flow one per cycle while the output accepts them; the output port's
// ready is what can hold that flow, and the output port emits at most one byte per cycle.
module crc8_debug_frame_encoder
  import cdfe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  cdfe_in_if.sink              in_item,
  cdfe_out_if.source           out_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_wdata
);

  logic [BYTE_W-1:0] crc_poly_r;
  logic [BYTE_W-1:0] cmd_code_r;
  logic              job_valid;
  logic              job_pop;
  job_t              job;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_poly_r <= CRC_POLY_RST;
      cmd_code_r <= CMD_CODE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CRC_POLY: crc_poly_r <= cfg_wdata;
        REG_CMD_CODE: cmd_code_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  cdfe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .job_pop   (job_pop),
    .job_valid (job_valid),
    .job       (job)
  );

  cdfe_serializer u_serializer (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job       (job),
    .crc_poly  (crc_poly_r),
    .cmd_code  (cmd_code_r),
    .job_pop   (job_pop),
    .out_item  (out_item)
  );

endmodule

/* src/cdfe_front.sv */
// Input stage: frame tracking, drop of stray bytes, length limiting, job register.
module cdfe_front
  import cdfe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  cdfe_in_if.sink    in_item,
  input  logic       job_pop,
  output logic       job_valid,
  output job_t       job
);

  logic             in_frame_r, in_frame_nxt;
  logic             job_valid_r, job_valid_nxt;
  job_t             job_r, job_nxt;
  logic             accept;
  logic             keep;
  logic [LEN_W-1:0] len_lim;

  // Take a new item whenever the job slot is free or drains this cycle
  assign in_item.ready = !job_valid_r || job_pop;
  assign accept = in_item.valid && in_item.ready;
  assign keep   = in_item.first_byte || in_frame_r;

  // Limit the sampled length to the legal range
  always_comb begin
    len_lim = in_item.payload_length;
    if (in_item.payload_length == '0) begin
      len_lim = LEN_W'(1);
    end else if (32'(in_item.payload_length) > MAX_PAYLOAD) begin
      len_lim = LEN_W'(MAX_PAYLOAD);
    end
  end

  // Next frame state, job slot and job contents
  always_comb begin
    in_frame_nxt  = in_frame_r;
    job_valid_nxt = job_valid_r;
    job_nxt       = job_r;
    if (job_pop) begin
      job_valid_nxt = 1'b0;
    end
    if (accept) begin
      if (keep) begin
        // A kept item opens or continues a frame; last closes it, even on a first item
        in_frame_nxt      = !in_item.last_byte;
        job_valid_nxt     = 1'b1;
        job_nxt.data_byte = in_item.data_byte;
        job_nxt.level     = in_item.message_level;
        job_nxt.len_byte  = BYTE_W'(len_lim) + BYTE_W'(LEN_EXTRA);
        job_nxt.first     = in_item.first_byte;
        job_nxt.last      = in_item.last_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r  <= 1'b0;
      job_valid_r <= 1'b0;
    end else begin
      in_frame_r  <= in_frame_nxt;
      job_valid_r <= job_valid_nxt;
    end
  end

  // Payload register
  always_ff @(posedge clk) begin
    job_r <= job_nxt;
  end

  assign job_valid = job_valid_r;
  assign job       = job_r;

endmodule

/* src/cdfe_serializer.sv */
// Byte sequencer: walks header, payload and trailer, updates the CRC, feeds the output register.
module cdfe_serializer
  import cdfe_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  input  job_t              job,
  input  logic [BYTE_W-1:0] crc_poly,
  input  logic [BYTE_W-1:0] cmd_code,
  output logic              job_pop,
  cdfe_out_if.source        out_item
);

  phase_t            phase_r, phase_nxt;
  phase_t            cur_phase;
  logic              started_r, started_nxt;
  logic [BYTE_W-1:0] crc_r, crc_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic              run_last_r, run_last_nxt;
  logic              frame_end_r, frame_end_nxt;
  logic              load;
  logic              is_end;
  logic [BYTE_W-1:0] cur_byte;

  // Current position: mid-job from the register, else the job's entry point
  always_comb begin
    if (started_r) begin
      cur_phase = phase_r;
    end else if (job.first) begin
      cur_phase = PH_HDR0;
    end else begin
      cur_phase = PH_DATA;
    end
  end

  // Advance when the output register is free or being emptied
  assign load    = job_valid && (!out_valid_r || out_item.ready);
  assign is_end  = (cur_phase == PH_LF) || ((cur_phase == PH_DATA) && !job.last);
  assign job_pop = load && is_end;

  // Select the byte and the following position
  always_comb begin
    cur_byte  = job.data_byte;
    phase_nxt = phase_r;
    case (cur_phase)
      PH_HDR0: begin cur_byte = HDR_BYTE0;     phase_nxt = PH_HDR1; end
      PH_HDR1: begin cur_byte = HDR_BYTE1;     phase_nxt = PH_CMD;  end
      PH_CMD:  begin cur_byte = cmd_code;      phase_nxt = PH_LEN;  end
      PH_LEN:  begin cur_byte = job.len_byte;  phase_nxt = PH_LVL;  end
      PH_LVL:  begin cur_byte = job.level;     phase_nxt = PH_DATA; end
      PH_DATA: begin cur_byte = job.data_byte; phase_nxt = PH_CRC;  end
      PH_CRC:  begin cur_byte = crc_r;         phase_nxt = PH_CR;   end
      PH_CR:   begin cur_byte = TAIL_CR;       phase_nxt = PH_LF;   end
      PH_LF:   begin cur_byte = TAIL_LF;       phase_nxt = PH_HDR0; end
      default: begin cur_byte = job.data_byte; phase_nxt = PH_DATA; end
    endcase
  end

  // Sequencer, CRC and output register next values
  always_comb begin
    started_nxt   = started_r;
    crc_nxt       = crc_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    run_last_nxt  = run_last_r;
    frame_end_nxt = frame_end_r;
    if (out_item.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      started_nxt   = !is_end;
      out_valid_nxt = 1'b1;
      out_byte_nxt  = cur_byte;
      run_last_nxt  = is_end;
      frame_end_nxt = (cur_phase == PH_LF);
      case (cur_phase)
        PH_HDR0: crc_nxt = '0;
        PH_CMD, PH_LEN, PH_LVL, PH_DATA: crc_nxt = crc8_update(crc_r, cur_byte, crc_poly);
        default: crc_nxt = crc_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r   <= 1'b0;
      phase_r     <= PH_HDR0;
      crc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      started_r   <= started_nxt;
      if (load) begin
        phase_r <= phase_nxt;
      end
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    out_byte_r  <= out_byte_nxt;
    run_last_r  <= run_last_nxt;
    frame_end_r <= frame_end_nxt;
  end

  assign out_item.valid     = out_valid_r;
  assign out_item.out_byte  = out_byte_r;
  assign out_item.run_last  = run_last_r;
  assign out_item.frame_end = frame_end_r;

endmodule
